[rtl/cpet_pkg.sv]
`timescale 1ns / 1ps

package cpet_pkg;

    localparam int unsigned COORD_W    = 24;
    localparam int unsigned RAD_W      = COORD_W - 1;
    localparam int unsigned TOL_W      = 24;
    localparam int unsigned GUARD      = 7;
    localparam int unsigned DIFF_W     = COORD_W + 1;
    localparam int unsigned DR_W       = RAD_W + 1;
    localparam int unsigned DSQ_W      = 2 * DIFF_W;
    localparam int unsigned DRSQ_W     = 2 * DR_W;
    localparam int unsigned ROOT_ARG_W = DSQ_W + 2 * GUARD;
    localparam int unsigned SQRT_STEPS = ROOT_ARG_W / 2;
    localparam int unsigned H_W        = SQRT_STEPS;
    localparam int unsigned TRIAL_W    = ROOT_ARG_W + 2;
    localparam int unsigned DRG_W      = DR_W + GUARD;
    localparam int unsigned PROD_W     = DIFF_W + H_W + 1;
    localparam int unsigned NUM_W      = PROD_W + 1;
    localparam int unsigned MAG_W      = DSQ_W + GUARD;
    localparam int unsigned MAG_LO_W   = (MAG_W + 1) / 2;
    localparam int unsigned MAG_HI_W   = MAG_W - MAG_LO_W;
    localparam int unsigned PART_W     = RAD_W + MAG_LO_W;
    localparam int unsigned DEN_W      = MAG_W;
    localparam int unsigned DVD_W      = RAD_W + MAG_W;
    localparam int unsigned QUOT_W     = RAD_W;
    localparam int unsigned SUM_W      = COORD_W + 2;
    localparam int unsigned ROT_STEPS  = 24;
    localparam int unsigned CX_W       = H_W + 4;
    localparam int unsigned Z_W        = 27;
    localparam int unsigned NUM_DIRS   = 4;
    localparam int unsigned DIV_LANES  = 2 * NUM_DIRS;
    localparam int unsigned DIV_LAT    = QUOT_W + 1;

    localparam int unsigned DIR_LX = 0;
    localparam int unsigned DIR_LY = 1;
    localparam int unsigned DIR_RX = 2;
    localparam int unsigned DIR_RY = 3;

    localparam int unsigned ST_ROOT    = 2;
    localparam int unsigned ST_H       = ST_ROOT + SQRT_STEPS;
    localparam int unsigned ST_PROD    = ST_H + 1;
    localparam int unsigned ST_NUM     = ST_PROD + 1;
    localparam int unsigned ST_PART    = ST_NUM + 1;
    localparam int unsigned ST_DVD     = ST_PART + 1;
    localparam int unsigned ST_REJ     = ST_PROD + ROT_STEPS + 1;
    localparam int unsigned ST_LAST    = ST_DVD + DIV_LAT;
    localparam int unsigned NUM_STAGES = ST_LAST + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RAD_W-1:0]          radius_t;
    typedef logic [TOL_W-1:0]          tol_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [DR_W-1:0]    dr_t;
    typedef logic [DSQ_W-1:0]          dsq_t;
    typedef logic [DRSQ_W-1:0]         drsq_t;
    typedef logic [ROOT_ARG_W-1:0]     root_arg_t;
    typedef logic [TRIAL_W-1:0]        trial_t;
    typedef logic [H_W-1:0]            h_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [PART_W-1:0]         part_t;
    typedef logic [DEN_W-1:0]          den_t;
    typedef logic [DVD_W-1:0]          dvd_t;
    typedef logic [QUOT_W:0]           quot_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [Z_W-1:0]     z_t;
    typedef logic signed [CX_W-1:0]    cx_t;

    localparam tol_t   TOL_RESET = tol_t'(17);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    localparam logic [Z_W-1:0] ATAN_Q24 [32] = '{
        27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331,
        27'd1047214, 27'd524117, 27'd262123, 27'd131069,
        27'd65536, 27'd32768, 27'd16384, 27'd8192,
        27'd4096, 27'd2048, 27'd1024, 27'd512,
        27'd256, 27'd128, 27'd64, 27'd32,
        27'd16, 27'd8, 27'd4, 27'd2,
        27'd1, 27'd0, 27'd0, 27'd0,
        27'd0, 27'd0, 27'd0, 27'd0
    };

    typedef struct packed {
        logic                bad;
        logic                rej;
        logic [NUM_DIRS-1:0] neg;
        coord_t              x1;
        coord_t              y1;
        coord_t              x2;
        coord_t              y2;
        radius_t             r1;
        radius_t             r2;
        diff_t               dx;
        diff_t               dy;
        dr_t                 dr;
        dsq_t                dsq;
    } geo_t;

    typedef struct packed {
        cx_t  x;
        cx_t  y;
        z_t   z;
        logic hz;
    } cordic_t;

    typedef struct packed {
        logic   found;
        coord_t left_start_x;
        coord_t left_start_y;
        coord_t left_end_x;
        coord_t left_end_y;
        coord_t right_start_x;
        coord_t right_start_y;
        coord_t right_end_x;
        coord_t right_end_y;
    } out_item_t;

    function automatic coord_t place(input coord_t c, input quot_t q, input logic neg);
        sum_t off;
        sum_t s;
        off = neg ? -sum_t'(q) : sum_t'(q);
        s = sum_t'(c) + off;
        if (s > sum_t'(COORD_MAX))
        begin
            return COORD_MAX;
        end
        else if (s < sum_t'(COORD_MIN))
        begin
            return COORD_MIN;
        end
        return coord_t'(s);
    endfunction

endpackage

[rtl/cpet_if.sv]
`timescale 1ns / 1ps

interface cpet_in_if;
    logic                     valid;
    logic                     ready;
    cpet_pkg::coord_t         first_center_x;
    cpet_pkg::coord_t         first_center_y;
    cpet_pkg::radius_t        first_radius;
    cpet_pkg::coord_t         second_center_x;
    cpet_pkg::coord_t         second_center_y;
    cpet_pkg::radius_t        second_radius;

    modport source (
        output valid, first_center_x, first_center_y, first_radius,
        output second_center_x, second_center_y, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_radius,
        input  second_center_x, second_center_y, second_radius,
        output ready
    );
endinterface

interface cpet_out_if;
    logic             valid;
    logic             ready;
    logic             found;
    cpet_pkg::coord_t left_start_x;
    cpet_pkg::coord_t left_start_y;
    cpet_pkg::coord_t left_end_x;
    cpet_pkg::coord_t left_end_y;
    cpet_pkg::coord_t right_start_x;
    cpet_pkg::coord_t right_start_y;
    cpet_pkg::coord_t right_end_x;
    cpet_pkg::coord_t right_end_y;

    modport source (
        output valid, found, left_start_x, left_start_y, left_end_x, left_end_y,
        output right_start_x, right_start_y, right_end_x, right_end_y,
        input  ready
    );
    modport sink (
        input  valid, found, left_start_x, left_start_y, left_end_x, left_end_y,
        input  right_start_x, right_start_y, right_end_x, right_end_y,
        output ready
    );
endinterface

interface cpet_cfg_if;
    logic           valid;
    logic           ready;
    cpet_pkg::tol_t angle_tolerance;

    modport source (output valid, angle_tolerance, input ready);
    modport sink (input valid, angle_tolerance, output ready);
endinterface

[rtl/cpet_div.sv]
`timescale 1ns / 1ps

module cpet_div (
    input  logic             clk,
    input  logic             en,
    input  cpet_pkg::dvd_t   dvd [cpet_pkg::DIV_LANES],
    input  cpet_pkg::den_t   den,
    output cpet_pkg::quot_t  quot [cpet_pkg::DIV_LANES]
);

    cpet_pkg::dvd_t rem_reg  [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    cpet_pkg::dvd_t rem_next [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    cpet_pkg::dvd_t rem_src  [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    logic [cpet_pkg::QUOT_W-1:0] q_reg  [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    logic [cpet_pkg::QUOT_W-1:0] q_next [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    logic [cpet_pkg::QUOT_W-1:0] q_src  [cpet_pkg::QUOT_W][cpet_pkg::DIV_LANES];
    cpet_pkg::den_t den_reg  [cpet_pkg::QUOT_W];
    cpet_pkg::den_t den_src  [cpet_pkg::QUOT_W];
    cpet_pkg::quot_t quot_reg  [cpet_pkg::DIV_LANES];
    cpet_pkg::quot_t quot_next [cpet_pkg::DIV_LANES];

    always_comb
    begin
        den_src[0] = den;
        for (int l = 0; l < cpet_pkg::DIV_LANES; l++)
        begin
            rem_src[0][l] = dvd[l];
            q_src[0][l] = '0;
        end
        for (int k = 1; k < cpet_pkg::QUOT_W; k++)
        begin
            den_src[k] = den_reg[k-1];
            for (int l = 0; l < cpet_pkg::DIV_LANES; l++)
            begin
                rem_src[k][l] = rem_reg[k-1][l];
                q_src[k][l] = q_reg[k-1][l];
            end
        end
    end

    always_comb
    begin
        cpet_pkg::dvd_t trial;
        for (int k = 0; k < cpet_pkg::QUOT_W; k++)
        begin
            trial = cpet_pkg::dvd_t'(den_src[k]) << (cpet_pkg::QUOT_W - 1 - k);
            for (int l = 0; l < cpet_pkg::DIV_LANES; l++)
            begin
                rem_next[k][l] = rem_src[k][l];
                q_next[k][l] = q_src[k][l];
                if (rem_src[k][l] >= trial)
                begin
                    rem_next[k][l] = rem_src[k][l] - trial;
                    q_next[k][l][cpet_pkg::QUOT_W - 1 - k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [cpet_pkg::DEN_W:0] twice;
        for (int l = 0; l < cpet_pkg::DIV_LANES; l++)
        begin
            twice = {rem_reg[cpet_pkg::QUOT_W-1][l][cpet_pkg::DEN_W-1:0], 1'b0};
            quot_next[l] = cpet_pkg::quot_t'(q_reg[cpet_pkg::QUOT_W-1][l])
                + cpet_pkg::quot_t'(twice >= {1'b0, den_reg[cpet_pkg::QUOT_W-1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            den_reg <= den_src;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

[rtl/circle_pair_external_tangents.sv]
`timescale 1ns / 1ps

// Finds the two external tangent segments of a pair of circles. Each item gives
// two centers and two radii with 8 fraction bits; the result gives the tangent
// points on both circles for the left and right segment, saturated, and found
// is low with all points zero for coincident centers, nested circles or a
// tangent angle closer to 0 or pi than the angle_tolerance register. The block
// takes one item per cycle while no result waits at the output; its pipeline
// holds the 32-step square root, the 24-step CORDIC angle check and the
// 23-step divider that scales the eight point offsets. While a result waits
// at the output the whole pipeline holds. Configuration writes are taken at
// once.
module circle_pair_external_tangents (
    input logic         clk,
    input logic         rst_n,
    cpet_in_if.sink     in_item,
    cpet_out_if.source  out_item,
    cpet_cfg_if.sink    cfg
);

    logic en;
    logic [cpet_pkg::NUM_STAGES-1:0] v_reg;
    logic out_valid_reg;
    cpet_pkg::tol_t tol_reg;
    cpet_pkg::geo_t g_reg  [cpet_pkg::NUM_STAGES];
    cpet_pkg::geo_t g_next [cpet_pkg::NUM_STAGES];

    logic [cpet_pkg::DIFF_W-1:0] adx;
    logic [cpet_pkg::DIFF_W-1:0] ady;
    logic [cpet_pkg::DR_W-1:0] adr;
    cpet_pkg::dsq_t sqx_reg;
    cpet_pkg::dsq_t sqy_reg;
    cpet_pkg::drsq_t sqr_reg;
    cpet_pkg::dsq_t dsq_w;

    cpet_pkg::root_arg_t rem_reg  [cpet_pkg::SQRT_STEPS+1];
    cpet_pkg::root_arg_t rem_next [cpet_pkg::SQRT_STEPS+1];
    cpet_pkg::h_t root_reg  [cpet_pkg::SQRT_STEPS+1];
    cpet_pkg::h_t root_next [cpet_pkg::SQRT_STEPS+1];

    cpet_pkg::h_t h;
    logic signed [cpet_pkg::H_W:0] h_s;
    logic signed [cpet_pkg::DRG_W-1:0] drg;
    logic [cpet_pkg::DR_W-1:0] adr_h;
    cpet_pkg::prod_t prod_reg [cpet_pkg::NUM_DIRS];
    cpet_pkg::num_t num_w [cpet_pkg::NUM_DIRS];
    logic [cpet_pkg::NUM_DIRS-1:0] neg_w;
    cpet_pkg::mag_t mag_reg [cpet_pkg::NUM_DIRS];
    cpet_pkg::part_t lo_reg [cpet_pkg::DIV_LANES];
    cpet_pkg::part_t hi_reg [cpet_pkg::DIV_LANES];
    cpet_pkg::dvd_t dvd_reg [cpet_pkg::DIV_LANES];
    cpet_pkg::quot_t quot [cpet_pkg::DIV_LANES];

    cpet_pkg::cordic_t c_reg  [cpet_pkg::ROT_STEPS+1];
    cpet_pkg::cordic_t c_next [cpet_pkg::ROT_STEPS+1];
    cpet_pkg::z_t z_eff;
    logic rej_w;

    cpet_pkg::out_item_t out_reg;
    cpet_pkg::out_item_t out_next;

    assign en = !out_valid_reg || out_item.ready;
    assign in_item.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= cpet_pkg::TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.angle_tolerance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[cpet_pkg::NUM_STAGES-2:0], in_item.valid};
            out_valid_reg <= v_reg[cpet_pkg::ST_LAST];
        end
    end

    assign adx = g_reg[0].dx[cpet_pkg::DIFF_W-1] ? -g_reg[0].dx : g_reg[0].dx;
    assign ady = g_reg[0].dy[cpet_pkg::DIFF_W-1] ? -g_reg[0].dy : g_reg[0].dy;
    assign adr = g_reg[0].dr[cpet_pkg::DR_W-1] ? -g_reg[0].dr : g_reg[0].dr;
    assign dsq_w = sqx_reg + sqy_reg;

    always_comb
    begin
        g_next[0].bad = 1'b0;
        g_next[0].rej = 1'b0;
        g_next[0].neg = '0;
        g_next[0].x1 = in_item.first_center_x;
        g_next[0].y1 = in_item.first_center_y;
        g_next[0].x2 = in_item.second_center_x;
        g_next[0].y2 = in_item.second_center_y;
        g_next[0].r1 = in_item.first_radius;
        g_next[0].r2 = in_item.second_radius;
        g_next[0].dx = cpet_pkg::diff_t'(in_item.second_center_x)
            - cpet_pkg::diff_t'(in_item.first_center_x);
        g_next[0].dy = cpet_pkg::diff_t'(in_item.second_center_y)
            - cpet_pkg::diff_t'(in_item.first_center_y);
        g_next[0].dr = cpet_pkg::dr_t'({1'b0, in_item.second_radius})
            - cpet_pkg::dr_t'({1'b0, in_item.first_radius});
        g_next[0].dsq = '0;
        for (int i = 1; i < cpet_pkg::NUM_STAGES; i++)
        begin
            g_next[i] = g_reg[i-1];
        end
        g_next[cpet_pkg::ST_ROOT].dsq = dsq_w;
        g_next[cpet_pkg::ST_ROOT].bad = (dsq_w == '0) || (dsq_w < cpet_pkg::dsq_t'(sqr_reg));
        g_next[cpet_pkg::ST_NUM].neg = neg_w;
        g_next[cpet_pkg::ST_REJ].rej = rej_w;
    end

    always_comb
    begin
        cpet_pkg::trial_t trial;
        rem_next[0] = {dsq_w - cpet_pkg::dsq_t'(sqr_reg), {(2 * cpet_pkg::GUARD){1'b0}}};
        root_next[0] = '0;
        for (int k = 1; k <= cpet_pkg::SQRT_STEPS; k++)
        begin
            trial = (cpet_pkg::trial_t'(root_reg[k-1]) << (cpet_pkg::SQRT_STEPS - k + 1))
                | (cpet_pkg::trial_t'(1) << (2 * (cpet_pkg::SQRT_STEPS - k)));
            rem_next[k] = rem_reg[k-1];
            root_next[k] = root_reg[k-1];
            if (cpet_pkg::trial_t'(rem_reg[k-1]) >= trial)
            begin
                rem_next[k] = rem_reg[k-1] - trial[cpet_pkg::ROOT_ARG_W-1:0];
                root_next[k] = root_reg[k-1]
                    | (cpet_pkg::h_t'(1) << (cpet_pkg::SQRT_STEPS - k));
            end
        end
    end

    assign h = root_reg[cpet_pkg::SQRT_STEPS];
    assign h_s = {1'b0, h};
    assign drg = {g_reg[cpet_pkg::ST_H].dr, {cpet_pkg::GUARD{1'b0}}};
    assign adr_h = g_reg[cpet_pkg::ST_H].dr[cpet_pkg::DR_W-1]
        ? -g_reg[cpet_pkg::ST_H].dr : g_reg[cpet_pkg::ST_H].dr;

    always_comb
    begin
        cpet_pkg::cordic_t cur;
        cpet_pkg::cx_t xs;
        cpet_pkg::cx_t ys;
        c_next[0].x = {{(cpet_pkg::CX_W - cpet_pkg::DR_W - cpet_pkg::GUARD){1'b0}},
            adr_h, {cpet_pkg::GUARD{1'b0}}};
        c_next[0].y = {{(cpet_pkg::CX_W - cpet_pkg::H_W){1'b0}}, h};
        c_next[0].z = '0;
        c_next[0].hz = (h == '0);
        for (int j = 1; j <= cpet_pkg::ROT_STEPS; j++)
        begin
            cur = c_reg[j-1];
            xs = cur.y >>> (j - 1);
            ys = cur.x >>> (j - 1);
            c_next[j] = cur;
            if (!cur.y[cpet_pkg::CX_W-1])
            begin
                c_next[j].x = cur.x + xs;
                c_next[j].y = cur.y - ys;
                c_next[j].z = cur.z + cpet_pkg::z_t'(cpet_pkg::ATAN_Q24[j-1]);
            end
            else
            begin
                c_next[j].x = cur.x - xs;
                c_next[j].y = cur.y + ys;
                c_next[j].z = cur.z - cpet_pkg::z_t'(cpet_pkg::ATAN_Q24[j-1]);
            end
        end
    end

    assign z_eff = c_reg[cpet_pkg::ROT_STEPS].hz ? '0 : c_reg[cpet_pkg::ROT_STEPS].z;
    assign rej_w = z_eff < $signed({1'b0, tol_reg});

    always_comb
    begin
        num_w[cpet_pkg::DIR_LX] = -(cpet_pkg::num_t'(prod_reg[0]) + cpet_pkg::num_t'(prod_reg[1]));
        num_w[cpet_pkg::DIR_LY] = cpet_pkg::num_t'(prod_reg[2]) - cpet_pkg::num_t'(prod_reg[3]);
        num_w[cpet_pkg::DIR_RX] = cpet_pkg::num_t'(prod_reg[0]) - cpet_pkg::num_t'(prod_reg[1]);
        num_w[cpet_pkg::DIR_RY] = -(cpet_pkg::num_t'(prod_reg[2]) + cpet_pkg::num_t'(prod_reg[3]));
        for (int n = 0; n < cpet_pkg::NUM_DIRS; n++)
        begin
            neg_w[n] = num_w[n][cpet_pkg::NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= g_next;
            sqx_reg <= adx * adx;
            sqy_reg <= ady * ady;
            sqr_reg <= adr * adr;
            rem_reg <= rem_next;
            root_reg <= root_next;
            c_reg <= c_next;
            prod_reg[0] <= cpet_pkg::prod_t'(g_reg[cpet_pkg::ST_H].dy) * cpet_pkg::prod_t'(h_s);
            prod_reg[1] <= cpet_pkg::prod_t'(g_reg[cpet_pkg::ST_H].dx) * cpet_pkg::prod_t'(drg);
            prod_reg[2] <= cpet_pkg::prod_t'(g_reg[cpet_pkg::ST_H].dx) * cpet_pkg::prod_t'(h_s);
            prod_reg[3] <= cpet_pkg::prod_t'(g_reg[cpet_pkg::ST_H].dy) * cpet_pkg::prod_t'(drg);
            for (int n = 0; n < cpet_pkg::NUM_DIRS; n++)
            begin
                mag_reg[n] <= cpet_pkg::mag_t'(neg_w[n] ? -num_w[n] : num_w[n]);
            end
            for (int m = 0; m < cpet_pkg::DIV_LANES; m++)
            begin
                lo_reg[m] <= ((m % 2 == 1) ? g_reg[cpet_pkg::ST_NUM].r2 : g_reg[cpet_pkg::ST_NUM].r1)
                    * mag_reg[m / 2][cpet_pkg::MAG_LO_W-1:0];
                hi_reg[m] <= ((m % 2 == 1) ? g_reg[cpet_pkg::ST_NUM].r2 : g_reg[cpet_pkg::ST_NUM].r1)
                    * mag_reg[m / 2][cpet_pkg::MAG_W-1:cpet_pkg::MAG_LO_W];
                dvd_reg[m] <= cpet_pkg::dvd_t'(lo_reg[m])
                    + (cpet_pkg::dvd_t'(hi_reg[m]) << cpet_pkg::MAG_LO_W);
            end
            out_reg <= out_next;
        end
    end

    cpet_div u_div (
        .clk  (clk),
        .en   (en),
        .dvd  (dvd_reg),
        .den  ({g_reg[cpet_pkg::ST_DVD].dsq, {cpet_pkg::GUARD{1'b0}}}),
        .quot (quot)
    );

    always_comb
    begin
        cpet_pkg::geo_t g;
        g = g_reg[cpet_pkg::ST_LAST];
        out_next = '0;
        if (!g.bad && !g.rej)
        begin
            out_next.found = 1'b1;
            out_next.left_start_x = cpet_pkg::place(g.x1, quot[0], g.neg[cpet_pkg::DIR_LX]);
            out_next.left_end_x = cpet_pkg::place(g.x2, quot[1], g.neg[cpet_pkg::DIR_LX]);
            out_next.left_start_y = cpet_pkg::place(g.y1, quot[2], g.neg[cpet_pkg::DIR_LY]);
            out_next.left_end_y = cpet_pkg::place(g.y2, quot[3], g.neg[cpet_pkg::DIR_LY]);
            out_next.right_start_x = cpet_pkg::place(g.x1, quot[4], g.neg[cpet_pkg::DIR_RX]);
            out_next.right_end_x = cpet_pkg::place(g.x2, quot[5], g.neg[cpet_pkg::DIR_RX]);
            out_next.right_start_y = cpet_pkg::place(g.y1, quot[6], g.neg[cpet_pkg::DIR_RY]);
            out_next.right_end_y = cpet_pkg::place(g.y2, quot[7], g.neg[cpet_pkg::DIR_RY]);
        end
    end

    assign out_item.valid = out_valid_reg;
    assign out_item.found = out_reg.found;
    assign out_item.left_start_x = out_reg.left_start_x;
    assign out_item.left_start_y = out_reg.left_start_y;
    assign out_item.left_end_x = out_reg.left_end_x;
    assign out_item.left_end_y = out_reg.left_end_y;
    assign out_item.right_start_x = out_reg.right_start_x;
    assign out_item.right_start_y = out_reg.right_start_y;
    assign out_item.right_end_x = out_reg.right_end_x;
    assign out_item.right_end_y = out_reg.right_end_y;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.found |->
            out_item.left_start_x == 0 && out_item.left_start_y == 0 &&
            out_item.left_end_x == 0 && out_item.left_end_y == 0 &&
            out_item.right_start_x == 0 && out_item.right_start_y == 0 &&
            out_item.right_end_x == 0 && out_item.right_end_y == 0)
        else $error("result without tangents carries nonzero points");

    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> v_reg == $past(v_reg))
        else $error("pipeline valid bits moved during a stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[cpet_pkg::ST_LAST] && !g_reg[cpet_pkg::ST_LAST].bad |->
            quot[0] <= {1'b0, g_reg[cpet_pkg::ST_LAST].r1})
        else $error("tangent offset exceeds the first radius");
`endif

endmodule

[verif/tb_circle_pair_external_tangents.sv]
`timescale 1ns / 1ps

module tb_circle_pair_external_tangents;

    localparam int LATENCY = 63;
    localparam int HOLD_LENGTH = 200;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpet_in_if  in_item ();
    cpet_out_if out_item ();
    cpet_cfg_if cfg ();

    circle_pair_external_tangents DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item.sink),
        .out_item (out_item.source),
        .cfg      (cfg.sink)
    );

    typedef struct {
        cpet_pkg::coord_t  x1;
        cpet_pkg::coord_t  y1;
        cpet_pkg::radius_t r1;
        cpet_pkg::coord_t  x2;
        cpet_pkg::coord_t  y2;
        cpet_pkg::radius_t r2;
    } pair_t;

    localparam longint ATAN_TABLE [32] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
    };

    cpet_pkg::out_item_t tangent_queue[$];
    cpet_pkg::tol_t      tolerance_now;
    int                  error_count = 0;
    longint              cycle_count = 0;
    int                  out_idle_pct = 16;
    int                  in_idle_pct = 16;
    int                  hold_request = 0;
    int                  hold_seen = 0;
    int                  hold_cycles = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint cordic_angle(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (y == 0)
            return 0;
        for (int i = 0; i < 24; i++)
        begin
            xs = floor_sh(y, i);
            ys = floor_sh(x, i);
            if (y >= 0)
            begin
                x = x + xs;
                y = y - ys;
                z = z + ATAN_TABLE[i];
            end
            else
            begin
                x = x - xs;
                y = y + ys;
                z = z - ATAN_TABLE[i];
            end
        end
        return z;
    endfunction

    function automatic longint point_offset(longint r, logic signed [127:0] num,
                                            logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] rem;
        mag = num < 0 ? -num : num;
        prod = mag * r;
        q = prod / den;
        rem = prod % den;
        if (rem >= den - rem)
            q = q + 1;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic cpet_pkg::coord_t clamp(longint v);
        if (v > 8388607)
            return cpet_pkg::COORD_MAX;
        if (v < -8388608)
            return cpet_pkg::COORD_MIN;
        return cpet_pkg::coord_t'(v);
    endfunction

    function automatic cpet_pkg::out_item_t tangent_points(pair_t p, cpet_pkg::tol_t tol);
        cpet_pkg::out_item_t o;
        longint dx, dy, dr, x1, y1, x2, y2, r1, r2;
        logic [63:0] dsq, drsq, h;
        logic signed [127:0] lx, ly, rx, ry, dh, drg;
        logic [127:0] den;
        o = '0;
        x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
        r1 = p.r1; r2 = p.r2;
        dx = x2 - x1;
        dy = y2 - y1;
        dr = r2 - r1;
        dsq = dx * dx + dy * dy;
        drsq = dr * dr;
        if (dsq == 0 || dsq < drsq)
            return o;
        h = int_sqrt((dsq - drsq) << 14);
        if (cordic_angle((dr < 0 ? -dr : dr) <<< 7, longint'(h)) < longint'(tol))
            return o;
        dh = $signed({64'd0, h});
        drg = dr * 128;
        den = {64'd0, dsq} << 7;
        lx = -(dy * dh + dx * drg);
        ly = dx * dh - dy * drg;
        rx = dy * dh - dx * drg;
        ry = -(dx * dh + dy * drg);
        o.found = 1'b1;
        o.left_start_x  = clamp(x1 + point_offset(r1, lx, den));
        o.left_start_y  = clamp(y1 + point_offset(r1, ly, den));
        o.left_end_x    = clamp(x2 + point_offset(r2, lx, den));
        o.left_end_y    = clamp(y2 + point_offset(r2, ly, den));
        o.right_start_x = clamp(x1 + point_offset(r1, rx, den));
        o.right_start_y = clamp(y1 + point_offset(r1, ry, den));
        o.right_end_x   = clamp(x2 + point_offset(r2, rx, den));
        o.right_end_y   = clamp(y2 + point_offset(r2, ry, den));
        return o;
    endfunction

    task automatic send_pair(pair_t p);
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_item.valid <= 1'b0;
            @(posedge clk);
        end
        in_item.valid <= 1'b1;
        in_item.first_center_x <= p.x1;
        in_item.first_center_y <= p.y1;
        in_item.first_radius <= p.r1;
        in_item.second_center_x <= p.x2;
        in_item.second_center_y <= p.y2;
        in_item.second_radius <= p.r2;
        @(posedge clk);
        while (!in_item.ready)
            @(posedge clk);
        tangent_queue.insert(tangent_queue.size(), tangent_points(p, tolerance_now));
    endtask

    task automatic drain_results();
        in_item.valid <= 1'b0;
        while (tangent_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_tolerance(cpet_pkg::tol_t v);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.angle_tolerance <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        tolerance_now = v;
    endtask

    always @(posedge clk)
    begin
        cpet_pkg::out_item_t want;
        if (out_item.valid && out_item.ready)
        begin
            if (tangent_queue.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d", $time, out_item.found);
                error_count++;
            end
            else
            begin
                want = tangent_queue.pop_front();
                if (want.found !== out_item.found
                    || want.left_start_x !== out_item.left_start_x
                    || want.left_start_y !== out_item.left_start_y
                    || want.left_end_x !== out_item.left_end_x
                    || want.left_end_y !== out_item.left_end_y
                    || want.right_start_x !== out_item.right_start_x
                    || want.right_start_y !== out_item.right_start_y
                    || want.right_end_x !== out_item.right_end_x
                    || want.right_end_y !== out_item.right_end_y)
                begin
                    $display("%0t: mismatch expected %0d (%0d,%0d)(%0d,%0d)(%0d,%0d)(%0d,%0d)",
                        $time, want.found, want.left_start_x, want.left_start_y,
                        want.left_end_x, want.left_end_y, want.right_start_x,
                        want.right_start_y, want.right_end_x, want.right_end_y);
                    $display("%0t: actual %0d (%0d,%0d)(%0d,%0d)(%0d,%0d)(%0d,%0d)",
                        $time, out_item.found, out_item.left_start_x,
                        out_item.left_start_y, out_item.left_end_x, out_item.left_end_y,
                        out_item.right_start_x, out_item.right_start_y,
                        out_item.right_end_x, out_item.right_end_y);
                    error_count++;
                end
            end
        end
        if (!rst_n)
            out_item.ready <= 1'b0;
        else if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_cycles <= HOLD_LENGTH;
            out_item.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_item.ready <= 1'b0;
        end
        else
            out_item.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic pair_t random_pair(int mode);
        pair_t p;
        int span;
        p.x1 = cpet_pkg::coord_t'($urandom);
        p.y1 = cpet_pkg::coord_t'($urandom);
        p.r1 = cpet_pkg::radius_t'($urandom);
        p.x2 = cpet_pkg::coord_t'($urandom);
        p.y2 = cpet_pkg::coord_t'($urandom);
        p.r2 = cpet_pkg::radius_t'($urandom);
        span = 1 << $urandom_range(4, 20);
        case (mode)
            0:
            begin
                p.x2 = p.x1 + cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.y2 = p.y1 + cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.r1 = cpet_pkg::radius_t'($urandom_range(0, span));
                p.r2 = cpet_pkg::radius_t'($urandom_range(0, span));
            end
            1:
            begin
                p.x1 = cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.y1 = cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.x2 = cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.y2 = cpet_pkg::coord_t'($urandom_range(0, 2 * span) - span);
                p.r1 = cpet_pkg::radius_t'($urandom_range(0, span));
                p.r2 = p.r1 + cpet_pkg::radius_t'($urandom_range(0, 3));
            end
            2:
            begin
                p.x2 = p.x1;
                p.y2 = p.y1 + cpet_pkg::coord_t'($urandom_range(0, 8));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        send_pair('{0, 0, 256, 2560, 0, 256});
        send_pair('{0, 0, 256, 2560, 0, 768});
        send_pair('{0, 0, 768, 0, 2560, 256});
        send_pair('{100, 100, 50, 100, 100, 60});
        send_pair('{0, 0, 1000, 100, 0, 10});
        send_pair('{0, 0, 1000, 500, 0, 500});
        send_pair('{0, 0, 0, 1, 0, 1});
        send_pair('{0, 0, 0, 1000, 0, 0});
        send_pair('{cpet_pkg::COORD_MIN, cpet_pkg::COORD_MIN, 23'h7fffff,
                    cpet_pkg::COORD_MAX, cpet_pkg::COORD_MAX, 23'h7fffff});
        send_pair('{cpet_pkg::COORD_MAX, cpet_pkg::COORD_MIN, 0,
                    cpet_pkg::COORD_MIN, cpet_pkg::COORD_MAX, 23'h7fffff});
        send_pair('{cpet_pkg::COORD_MAX, cpet_pkg::COORD_MAX, 23'h7fffff,
                    cpet_pkg::COORD_MAX - 1000, cpet_pkg::COORD_MAX, 23'h7fffff});
        send_pair('{cpet_pkg::COORD_MIN, 0, 23'h400000,
                    cpet_pkg::COORD_MIN + 256, 0, 23'h400000});
        send_pair('{0, 0, 100, 3, 4, 95});
        send_pair('{0, 0, 100, -3, -4, 105});
        send_pair('{-500, 700, 300, 900, -1200, 10});
        send_pair('{5, 5, 23'h7fffff, 6, 5, 23'h7ffffe});
        p = '{0, 0, 0, 0, 1, 0};
        send_pair(p);
    endtask

    task automatic test_tolerance_sweep();
        cpet_pkg::tol_t settings[4] = '{cpet_pkg::tol_t'(0), cpet_pkg::tol_t'(24'hffffff),
                                        cpet_pkg::tol_t'(1 << 20), cpet_pkg::TOL_RESET};
        foreach (settings[k])
        begin
            write_tolerance(settings[k]);
            for (int i = 0; i < 40; i++)
                send_pair(random_pair(i % 4));
            send_pair('{0, 0, 1000, 500, 0, 500});
        end
    endtask

    task automatic test_random_stream();
        in_idle_pct = 0;
        out_idle_pct = 0;
        for (int i = 0; i < 300; i++)
            send_pair(random_pair($urandom_range(0, 3)));
        in_idle_pct = 16;
        out_idle_pct = 16;
        for (int i = 0; i < 1200; i++)
            send_pair(random_pair($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3)));
    endtask

    task automatic test_backpressure();
        hold_request = hold_request + 1;
        for (int i = 0; i < 120; i++)
            send_pair(random_pair(0));
        drain_results();
        for (int i = 0; i < 20; i++)
            send_pair(random_pair(1));
    endtask

    initial
    begin
        in_item.valid = 1'b0;
        in_item.first_center_x = '0;
        in_item.first_center_y = '0;
        in_item.first_radius = '0;
        in_item.second_center_x = '0;
        in_item.second_center_y = '0;
        in_item.second_radius = '0;
        cfg.valid = 1'b0;
        cfg.angle_tolerance = '0;
        tolerance_now = cpet_pkg::TOL_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tolerance_sweep();
        test_backpressure();
        test_random_stream();
        drain_results();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
